/* hdl/mi3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants of the 3x3 matrix inverse: determinant output format and
// the element indexes of the nine 2x2 cofactors.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int DET_OUT_W    = 64;
	localparam int DET_OUT_FRAC = 32;
	localparam int N_ELEM       = 9;

	// Adjugate entry k is e[x]*e[y] - e[z]*e[v], listed as {x, y, z, v}.
	localparam int CF_IDX [0:N_ELEM-1][0:3] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

endpackage

/* hdl/mi3_cofactor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two pipeline stages: the eighteen element products, then the nine
// adjugate entries. The first row travels along for the determinant.
// ----------------------------------------------------------------------------
module mi3_cofactor
	import mi3_pkg::*;
#(
	parameter int ELEM_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [ELEM_WIDTH-1:0]  e     [0:N_ELEM-1],
	output logic signed [2*ELEM_WIDTH:0]  adj   [0:N_ELEM-1],
	output logic signed [ELEM_WIDTH-1:0]  row0  [0:2]
);

	localparam int E  = ELEM_WIDTH;
	localparam int PW = 2 * E;
	localparam int AW = 2 * E + 1;

	logic signed [PW-1:0] pa_s1 [0:N_ELEM-1];
	logic signed [PW-1:0] pb_s1 [0:N_ELEM-1];
	logic signed [E-1:0]  row_s1 [0:2];
	logic signed [AW-1:0] adj_s2 [0:N_ELEM-1];
	logic signed [E-1:0]  row_s2 [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_ELEM; k++) begin
				pa_s1[k]  <= PW'(e[CF_IDX[k][0]]) * PW'(e[CF_IDX[k][1]]);
				pb_s1[k]  <= PW'(e[CF_IDX[k][2]]) * PW'(e[CF_IDX[k][3]]);
				adj_s2[k] <= AW'(pa_s1[k]) - AW'(pb_s1[k]);
			end
			for (int j = 0; j < 3; j++) begin
				row_s1[j] <= e[j];
				row_s2[j] <= row_s1[j];
			end
		end
	end

	assign adj  = adj_s2;
	assign row0 = row_s2;

endmodule

/* hdl/mi3_det.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det
// Three pipeline stages: split partial products of the first-row expansion,
// the determinant sum, then the determinant output, the singular flag and
// the dividend and divisor of each of the nine divisions.
// ----------------------------------------------------------------------------
module mi3_det
	import mi3_pkg::*;
#(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int RW         = 132,
	parameter int DTW        = 99
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [2*ELEM_WIDTH:0]  adj   [0:N_ELEM-1],
	input  logic signed [ELEM_WIDTH-1:0]  row0  [0:2],
	output logic        [RW-1:0]          num   [0:N_ELEM-1],
	output logic        [DTW-1:0]         den,
	output logic        [N_ELEM-1:0]      neg,
	output logic        [DET_OUT_W-1:0]   det_out,
	output logic                          sing
);

	localparam int E  = ELEM_WIDTH;
	localparam int AW = 2 * E + 1;
	localparam int MW = 2 * E;
	localparam int QW = DTW + DET_OUT_FRAC + 2;

	logic signed [AW-1:0]  plo_s3 [0:2];
	logic signed [AW-1:0]  phi_s3 [0:2];
	logic        [MW-1:0]  mag_s3 [0:N_ELEM-1];
	logic        [N_ELEM-1:0] an_s3;
	logic signed [DTW-1:0] det_s4;
	logic        [MW-1:0]  mag_s4 [0:N_ELEM-1];
	logic        [N_ELEM-1:0] an_s4;
	logic        [RW-1:0]  num_s5 [0:N_ELEM-1];
	logic        [DTW-1:0] den_s5;
	logic        [N_ELEM-1:0] neg_s5;
	logic        [DET_OUT_W-1:0] dout_s5;
	logic                  sing_s5;

	logic signed [AW-1:0]  adj_neg [0:N_ELEM-1];
	logic signed [DTW-1:0] det_sum;
	logic signed [DTW-1:0] det_negv;
	logic        [DTW-1:0] md;
	logic signed [QW-1:0]  dq;
	logic                  dq_fits;

	always_comb begin
		for (int k = 0; k < N_ELEM; k++) begin
			adj_neg[k] = -adj[k];
		end
		det_sum = '0;
		for (int j = 0; j < 3; j++) begin
			det_sum = det_sum + (DTW'(phi_s3[j]) <<< E) + DTW'(plo_s3[j]);
		end
		det_negv = -det_s4;
		md       = det_s4[DTW-1] ? det_negv : det_s4;
	end

	generate
		if (3 * FRAC_BITS > DET_OUT_FRAC) begin : g_round
			assign dq = (QW'(det_s4) + (QW'(1) <<< (3 * FRAC_BITS - DET_OUT_FRAC - 1)))
				>>> (3 * FRAC_BITS - DET_OUT_FRAC);
		end else begin : g_widen
			assign dq = QW'(det_s4) <<< (DET_OUT_FRAC - 3 * FRAC_BITS);
		end
	endgenerate

	assign dq_fits = (dq[QW-1:DET_OUT_W-1] == '0) || (dq[QW-1:DET_OUT_W-1] == '1);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= AW'(row0[j]) * AW'($signed({1'b0, adj[3*j][E-1:0]}));
				phi_s3[j] <= AW'(row0[j]) * AW'($signed(adj[3*j][AW-1:E]));
			end
			for (int k = 0; k < N_ELEM; k++) begin
				an_s3[k]  <= adj[k][AW-1];
				mag_s3[k] <= adj[k][AW-1] ? MW'(adj_neg[k]) : MW'(adj[k]);
				mag_s4[k] <= mag_s3[k];
				num_s5[k] <= (RW'(mag_s4[k]) << (2 * FRAC_BITS + 1)) + RW'(md);
				neg_s5[k] <= (an_s4[k] && (mag_s4[k] != '0)) ^ det_s4[DTW-1];
			end
			an_s4   <= an_s3;
			det_s4  <= det_sum;
			den_s5  <= md << 1;
			sing_s5 <= (det_s4 == '0);
			if (dq_fits) begin
				dout_s5 <= dq[DET_OUT_W-1:0];
			end else begin
				dout_s5 <= dq[QW-1] ? {1'b1, {(DET_OUT_W-1){1'b0}}}
				                    : {1'b0, {(DET_OUT_W-1){1'b1}}};
			end
		end
	end

	assign num     = num_s5;
	assign den     = den_s5;
	assign neg     = neg_s5;
	assign det_out = dout_s5;
	assign sing    = sing_s5;

endmodule

/* hdl/mi3_div_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider: one range check stage, then one quotient
// bit per stage, most significant first.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
	parameter int QB  = 33,
	parameter int RW  = 132,
	parameter int DTW = 99
) (
	input  logic           clk,
	input  logic           en,
	input  logic [RW-1:0]  num,
	input  logic [DTW-1:0] den,
	output logic [QB-1:0]  quo,
	output logic           ovf
);

	logic [RW-1:0]  rem_s [0:QB];
	logic [DTW-1:0] den_s [0:QB];
	logic [QB-1:0]  quo_s [0:QB];
	logic           ovf_s [0:QB];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= num >= (RW'(den) << QB);
			for (int i = 1; i <= QB; i++) begin
				den_s[i] <= den_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
				if (rem_s[i-1] >= (RW'(den_s[i-1]) << (QB - i))) begin
					rem_s[i] <= rem_s[i-1] - (RW'(den_s[i-1]) << (QB - i));
					quo_s[i] <= quo_s[i-1] | (QB'(1) << (QB - i));
				end else begin
					rem_s[i] <= rem_s[i-1];
					quo_s[i] <= quo_s[i-1];
				end
			end
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];

endmodule

/* hdl/matrix3_inverse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse
// One item is taken per cycle while the output is not stalled, through the
// cofactor, determinant and divider pipeline stages. The divider has a range
// check stage and one stage per quotient bit, ELEM_WIDTH + 2 in all.
// A stalled output holds the whole pipeline; arst_n clears the valid bits.
// ----------------------------------------------------------------------------
module matrix3_inverse
	import mi3_pkg::*;
#(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// e00, e01, e02, e10, e11, e12, e20, e21, e22, zero fill
	input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, det_value
	output logic [((9*ELEM_WIDTH+64+7)/8)*8-1:0] m_axis_tdata,
	// singular
	output logic [0:0]                  m_axis_tuser
);

	localparam int E    = ELEM_WIDTH;
	localparam int QB   = E + 1;
	localparam int DTW  = 3 * E + 3;
	localparam int RWA  = 2 * E + 2 * FRAC_BITS + 2;
	localparam int RW   = (RWA > 4 * E + 4) ? RWA : 4 * E + 4;
	localparam int DL   = QB + 1;
	localparam int LAT  = 5 + DL + 1;
	localparam int OTW  = ((9 * E + DET_OUT_W + 7) / 8) * 8;

	logic en;
	logic [LAT-1:0] vld_q;

	logic signed [E-1:0]   elem  [0:N_ELEM-1];
	logic signed [2*E:0]   adj   [0:N_ELEM-1];
	logic signed [E-1:0]   row0  [0:2];
	logic [RW-1:0]         num   [0:N_ELEM-1];
	logic [DTW-1:0]        den;
	logic [N_ELEM-1:0]     neg;
	logic [DET_OUT_W-1:0]  det_out;
	logic                  sing;
	logic [QB-1:0]         quo   [0:N_ELEM-1];
	logic                  ovf   [0:N_ELEM-1];

	logic [N_ELEM-1:0]     neg_q  [0:DL-1];
	logic [DET_OUT_W-1:0]  det_q  [0:DL-1];
	logic                  sing_q [0:DL-1];

	logic [E-1:0]          inv_q  [0:N_ELEM-1];
	logic [DET_OUT_W-1:0]  dout_q;
	logic                  sout_q;
	logic [E-1:0]          inv_d  [0:N_ELEM-1];
	logic [E-1:0]          qneg   [0:N_ELEM-1];

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	always_comb begin
		for (int k = 0; k < N_ELEM; k++) begin
			elem[k] = $signed(s_axis_tdata[k*E +: E]);
		end
	end

	mi3_cofactor #(.ELEM_WIDTH(E)) u_cofactor (
		.clk  (clk),
		.en   (en),
		.e    (elem),
		.adj  (adj),
		.row0 (row0)
	);

	mi3_det #(.ELEM_WIDTH(E), .FRAC_BITS(FRAC_BITS), .RW(RW), .DTW(DTW)) u_det (
		.clk     (clk),
		.en      (en),
		.adj     (adj),
		.row0    (row0),
		.num     (num),
		.den     (den),
		.neg     (neg),
		.det_out (det_out),
		.sing    (sing)
	);

	for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
		mi3_div_lane #(.QB(QB), .RW(RW), .DTW(DTW)) u_lane (
			.clk (clk),
			.en  (en),
			.num (num[k]),
			.den (den),
			.quo (quo[k]),
			.ovf (ovf[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_q[0]  <= neg;
			det_q[0]  <= det_out;
			sing_q[0] <= sing;
			for (int i = 1; i < DL; i++) begin
				neg_q[i]  <= neg_q[i-1];
				det_q[i]  <= det_q[i-1];
				sing_q[i] <= sing_q[i-1];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < N_ELEM; k++) begin
			qneg[k] = -quo[k][E-1:0];
			if (sing_q[DL-1]) begin
				inv_d[k] = '0;
			end else if (neg_q[DL-1][k]) begin
				if (ovf[k] || quo[k][E] || (quo[k][E-1] && (quo[k][E-2:0] != '0))) begin
					inv_d[k] = {1'b1, {(E-1){1'b0}}};
				end else begin
					inv_d[k] = qneg[k];
				end
			end else begin
				if (ovf[k] || quo[k][E] || quo[k][E-1]) begin
					inv_d[k] = {1'b0, {(E-1){1'b1}}};
				end else begin
					inv_d[k] = quo[k][E-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_ELEM; k++) begin
				inv_q[k] <= inv_d[k];
			end
			dout_q <= det_q[DL-1];
			sout_q <= sing_q[DL-1];
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int k = 0; k < N_ELEM; k++) begin
			m_axis_tdata[k*E +: E] = inv_q[k];
		end
		m_axis_tdata[9*E +: DET_OUT_W] = dout_q;
	end

	assign m_axis_tuser = sout_q;

	a_sing_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[OTW-1:0] == '0))
		else $error("singular item carries a nonzero inverse or determinant");

	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

	a_entry : assert property (@(posedge clk) disable iff (!arst_n)
		$past(en) |-> (vld_q[0] == $past(s_axis_tvalid)))
		else $error("pipeline entry valid does not follow the offered item");

endmodule

/* tb/tb_matrix3_inverse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3_inverse
// Self-checking bench for the 3x3 matrix inverse. A directed table of
// matrices (identity, zero, extremes, tiny and huge determinants, singular
// cases) is followed by random matrices of several kinds. Each item is
// checked against an exact wide-integer prediction or a hand-written
// expected result, under random gaps on both sides of the stream.
// ----------------------------------------------------------------------------
module tb_matrix3_inverse;
	import mi3_pkg::*;

	localparam int EW      = 32;
	localparam int FB      = 16;
	localparam int IN_W    = ((9*EW+7)/8)*8;
	localparam int OUT_W   = ((9*EW+64+7)/8)*8;
	localparam int N_RAND  = 1700;
	localparam int LATENCY = EW + 8;

	typedef logic [EW-1:0] elem_t;
	typedef elem_t matrix_t [9];
	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic [OUT_W-1:0] data;
		logic             singular;
	} inverse_t;

	typedef struct {
		matrix_t  m;
		bit       typed;
		inverse_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;

	inverse_t expected_inverses [$];
	int errors = 0;
	bit send_done = 0;
	bit quiet = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	matrix3_inverse u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	function automatic logic [63:0] clamp(wide_t x, int bits);
		wide_t hi;
		wide_t lo;
		hi = (256'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) begin
			x = hi;
		end else if (x < lo) begin
			x = lo;
		end
		return 64'(x) & ((bits >= 64) ? ~64'd0 : ((64'd1 << bits) - 1));
	endfunction

	function automatic inverse_t predict_inverse(matrix_t m);
		int cof [9][4] = '{
			'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
			'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
			'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
		};
		wide_t e [9];
		wide_t adj [9];
		wide_t det;
		wide_t mag_det;
		wide_t num;
		wide_t mag_num;
		wide_t q;
		inverse_t r;
		for (int k = 0; k < 9; k++) begin
			e[k] = $signed(m[k]);
		end
		for (int k = 0; k < 9; k++) begin
			adj[k] = e[cof[k][0]] * e[cof[k][1]] - e[cof[k][2]] * e[cof[k][3]];
		end
		det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
		r.data = '0;
		r.data[9*EW +: 64] = clamp((det + (256'sd1 <<< (3*FB - DET_OUT_FRAC - 1)))
			>>> (3*FB - DET_OUT_FRAC), DET_OUT_W);
		r.singular = (det == 0);
		if (det != 0) begin
			mag_det = (det < 0) ? -det : det;
			for (int k = 0; k < 9; k++) begin
				num = adj[k] <<< (2*FB);
				mag_num = (num < 0) ? -num : num;
				q = (2 * mag_num + mag_det) / (2 * mag_det);
				if ((num < 0) != (det < 0)) begin
					q = -q;
				end
				r.data[k*EW +: EW] = EW'(clamp(q, EW));
			end
		end
		return r;
	endfunction

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic elem_t small_value();
		return elem_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
	endfunction

	function automatic matrix_t random_matrix();
		matrix_t m;
		int kind;
		int r;
		kind = $urandom_range(0, 9);
		for (int k = 0; k < 9; k++) begin
			case (kind)
				0, 1, 2: m[k] = $urandom;
				3: m[k] = elem_t'($signed($urandom_range(0, 64)) - 32);
				default: m[k] = small_value();
			endcase
		end
		if (kind == 8) begin
			r = $urandom_range(1, 2);
			for (int c = 0; c < 3; c++) begin
				m[r*3 + c] = m[c];
			end
		end else if (kind == 9) begin
			for (int k = 0; k < 9; k++) begin
				if (k % 4 == 0) begin
					m[k] = elem_t'((k % 8 == 0 ? 1 : -1) * (6 << FB));
				end
			end
		end
		return m;
	endfunction

	task automatic send_matrix(matrix_t m, bit typed, inverse_t want);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		for (int k = 0; k < 9; k++) begin
			s_axis_tdata[k*EW +: EW] <= m[k];
		end
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_inverses.push_back(typed ? want : predict_inverse(m));
	endtask

	initial begin
		row_t rows [$];
		row_t row;
		elem_t one;
		elem_t vmax;
		elem_t vmin;
		int wait_cycles;
		one = elem_t'(1 << FB);
		vmax = {1'b0, {(EW-1){1'b1}}};
		vmin = {1'b1, {(EW-1){1'b0}}};

		row.typed = 1;
		row.m = '{one, 0, 0, 0, one, 0, 0, 0, one};
		row.want.data = '0;
		row.want.singular = 0;
		for (int k = 0; k < 9; k += 4) begin
			row.want.data[k*EW +: EW] = one;
		end
		row.want.data[9*EW +: 64] = 64'd1 << DET_OUT_FRAC;
		rows.push_back(row);
		row.m = '{default: 0};
		row.want.data = '0;
		row.want.singular = 1;
		rows.push_back(row);
		row.m = '{default: vmax};
		rows.push_back(row);
		row.m = '{default: vmin};
		rows.push_back(row);
		row.m = '{default: one};
		rows.push_back(row);
		row.typed = 0;
		row.m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		rows.push_back(row);
		row.m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
		rows.push_back(row);
		row.m = '{vmax, 0, 0, 0, vmax, 0, 0, 0, vmax};
		rows.push_back(row);
		row.m = '{vmin, 0, 0, 0, vmin, 0, 0, 0, vmin};
		rows.push_back(row);
		row.m = '{vmin, 0, 0, 0, vmax, 0, 0, 0, vmax};
		rows.push_back(row);
		row.m = '{2*one, 0, 0, 0, 2*one, 0, 0, 0, 2*one};
		rows.push_back(row);
		row.m = '{3*one, 0, 0, 0, 3*one, 0, 0, 0, 3*one};
		rows.push_back(row);
		row.m = '{0, one, 0, 0, 0, one, one, 0, 0};
		rows.push_back(row);
		row.m = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 10*one};
		rows.push_back(row);
		row.m = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 9*one};
		rows.push_back(row);
		row.m = '{default: 32'hAAAA_AAAA};
		row.m[4] = 32'h5555_5555;
		rows.push_back(row);
		row.m = '{32'h5555_5555, 32'hAAAA_AAAA, 1, vmin, vmax, -1, 7, one, -one};
		rows.push_back(row);
		row.m = '{vmax, vmin, vmax, vmin, vmax, vmin, vmax, vmin, 1};
		rows.push_back(row);
		row.m = '{1, 1, 0, 0, 1, 1, 1, 0, 1};
		rows.push_back(row);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_matrix(rows[i].m, rows[i].typed, rows[i].want);
		end
		for (int n = 0; n < N_RAND; n++) begin
			if (n % 150 == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			if (n == N_RAND / 2) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (expected_inverses.size() != 0) @(posedge clk);
			end
			send_matrix(random_matrix(), 0, row.want);
		end
		s_axis_tvalid <= 1'b0;
		while (expected_inverses.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0) begin
			$display("tb_matrix3_inverse: PASS");
		end else begin
			$display("tb_matrix3_inverse: FAIL");
		end
		$finish;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		inverse_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_inverses.size() == 0) begin
				$display("%0t: unexpected item %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = expected_inverses.pop_front();
				for (int k = 0; k < 9; k++) begin
					if (m_axis_tdata[k*EW +: EW] !== want.data[k*EW +: EW]) begin
						$display("%0t: inv%0d%0d expected %h actual %h", $time, k / 3,
							k % 3, want.data[k*EW +: EW], m_axis_tdata[k*EW +: EW]);
						errors++;
					end
				end
				if (m_axis_tdata[9*EW +: 64] !== want.data[9*EW +: 64]) begin
					$display("%0t: det_value expected %h actual %h", $time,
						want.data[9*EW +: 64], m_axis_tdata[9*EW +: 64]);
					errors++;
				end
				if (m_axis_tuser[0] !== want.singular) begin
					$display("%0t: singular expected %b actual %b", $time,
						want.singular, m_axis_tuser[0]);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("tb_matrix3_inverse: FAIL");
		$finish;
	end

endmodule
